[hw/rtl/psrr_pkg.sv]
// Shared sizes, request types and state encodings for the segment reverse/rotate block.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`default_nettype none

package psrr_pkg;

  // Store size and the widths that follow from it.
  localparam int MaxEntries = 64;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);

  // Field widths fixed by the interface.
  localparam int ValW = 7;
  localparam int OpW  = 2;
  localparam int CfgW = 7;

  // Request queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_INIT    = 2'd0,
    OP_REVERSE = 2'd1,
    OP_ROTATE  = 2'd2,
    OP_DUMP    = 2'd3
  } op_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    op_t             op;
    logic [ValW-1:0] first_value;
    logic [ValW-1:0] second_value;
    logic [CntW-1:0] count;
  } cmd_t;

  // Queue status as seen by the back end.
  typedef struct packed {
    cmd_t head;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_CHECK,
    BK_RV_READ,
    BK_RV_WLO,
    BK_RV_WHI,
    BK_RT_READ,
    BK_RT_MOVE,
    BK_RT_SHIFT,
    BK_RT_LAST
  } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/permutation_segment_reverse_rotate.sv]
// Top level of the permutation store with segment reverse and rotate.
// Depends on psrr_pkg and instantiates psrr_front, psrr_queue and psrr_back.
`default_nettype none

// A request is taken at any clock edge where start is high and busy is low; a
// two-deep queue lets the next requests be taken while one is carried out, and
// busy rises only when that queue is full. Each request is worked by the back
// end from a single-write, dual-read order store, so its time depends on the
// entry count n in use. Init is done once it is dispatched; a dump sweeps the
// store and shows its entries on out_strobe on consecutive cycles, the last
// marked by out_last_entry; reverse and rotate first sweep the store to find
// both values and check the positions, then reverse reads and writes back each
// swapped pair in turn, and rotate moves the front entry of the segment to its
// end and shifts the rest one place toward the front. Results cannot be held off
// by the receiver, so each one must be captured in the cycle its strobe is high.
// The entry count is writable at any time but must only be changed while no
// request is pending. There is no clearing pass after reset.
module permutation_segment_reverse_rotate (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [psrr_pkg::OpW-1:0]  in_opcode,
  input  wire logic [psrr_pkg::ValW-1:0] in_first_value,
  input  wire logic [psrr_pkg::ValW-1:0] in_second_value,
  output logic                           out_strobe,
  output logic [psrr_pkg::ValW-1:0]      out_entry_value,
  output logic                           out_last_entry,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [psrr_pkg::CfgW-1:0] cfg_entry_count
);

  logic               q_full;
  logic               push;
  logic               q_pop;
  psrr_pkg::cmd_t     push_cmd;
  psrr_pkg::q_stat_t  q_stat;

  // Request intake and classification.
  psrr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_opcode       (in_opcode),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_entry_count (cfg_entry_count),
    .q_full          (q_full),
    .busy            (busy),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Queue between the two halves.
  psrr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .stat     (q_stat)
  );

  // Store and sequencer.
  psrr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry)
  );

  // A taken request is in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !q_stat.empty)
    else $error("accepted request did not reach the queue");

  // Dump entries come on consecutive cycles until the marked last one.
  a_dump_continuous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_entry) |=> out_strobe)
    else $error("dump stream broke before its last entry");

  // The last entry of a dump ends the stream.
  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_entry) |=> !out_strobe)
    else $error("result shown right after the last entry of a dump");

endmodule

`default_nettype wire

[hw/rtl/psrr_front.sv]
// Front end: holds the entry count register, accepts requests and classifies them.
// Depends on psrr_pkg; feeds psrr_queue.
`default_nettype none

module psrr_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [psrr_pkg::OpW-1:0] in_opcode,
  input  wire logic [psrr_pkg::ValW-1:0] in_first_value,
  input  wire logic [psrr_pkg::ValW-1:0] in_second_value,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [psrr_pkg::CfgW-1:0] cfg_entry_count,
  input  wire logic                     q_full,
  output logic                          busy,
  output logic                          push,
  output psrr_pkg::cmd_t                push_cmd
);

  logic [psrr_pkg::CfgW-1:0] entry_count_r;
  logic [psrr_pkg::CfgW-1:0] entry_count_nxt;
  logic [psrr_pkg::CntW-1:0] active_count;

  // The register is always writable; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_comb begin
    entry_count_nxt = entry_count_r;
    if (cfg_valid && cfg_ready) begin
      entry_count_nxt = cfg_entry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= psrr_pkg::CfgW'(psrr_pkg::MaxEntries);
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  // Clamp the count in use to 1..MaxEntries; zero acts as one.
  always_comb begin
    if (entry_count_r == '0) begin
      active_count = psrr_pkg::CntW'(1);
    end else if (entry_count_r > psrr_pkg::CfgW'(psrr_pkg::MaxEntries)) begin
      active_count = psrr_pkg::CntW'(psrr_pkg::MaxEntries);
    end else begin
      active_count = psrr_pkg::CntW'(entry_count_r);
    end
  end

  // A request is taken whenever the queue has room.
  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_cmd.op           = psrr_pkg::op_t'(in_opcode);
    push_cmd.first_value  = in_first_value;
    push_cmd.second_value = in_second_value;
    push_cmd.count        = active_count;
  end

endmodule

`default_nettype wire

[hw/rtl/psrr_queue.sv]
// Short request queue between the front end and the back end.
// Depends on psrr_pkg for the request type and depth.
`default_nettype none

module psrr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire psrr_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output psrr_pkg::q_stat_t   stat
);

  psrr_pkg::cmd_t              slot_r [psrr_pkg::QueueDepth];
  logic [psrr_pkg::QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [psrr_pkg::QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [psrr_pkg::QCntW-1:0]  fill_r, fill_nxt;
  logic                        do_push, do_pop;

  assign full       = (fill_r == psrr_pkg::QCntW'(psrr_pkg::QueueDepth));
  assign stat.empty = (fill_r == '0);
  assign stat.head  = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !stat.empty;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == psrr_pkg::QPtrW'(psrr_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == psrr_pkg::QPtrW'(psrr_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Request storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/psrr_back.sv]
// Back end: the order store and the sequencer that searches, permutes and dumps it.
// Depends on psrr_pkg; takes requests from psrr_queue.
`default_nettype none

module psrr_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire psrr_pkg::q_stat_t         q_stat,
  output logic                           q_pop,
  output logic                           out_strobe,
  output logic [psrr_pkg::ValW-1:0]      out_entry_value,
  output logic                           out_last_entry
);

  localparam int AddrW = psrr_pkg::AddrW;
  localparam int CntW  = psrr_pkg::CntW;
  localparam int ValW  = psrr_pkg::ValW;

  // Order store: one write port, two registered read ports. An entry whose
  // valid bit is clear reads as the identity value, position plus one.
  logic [ValW-1:0]              store_mem [psrr_pkg::MaxEntries];
  logic [psrr_pkg::MaxEntries-1:0] vld_r;

  logic             rd_a_en, rd_b_en, wr_en, clr_all;
  logic [AddrW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [ValW-1:0]  wr_data;

  logic [ValW-1:0]  rdat_a_r, rdat_b_r;
  logic             rvld_a_r, rvld_b_r;
  logic [AddrW-1:0] radr_a_r, radr_b_r;
  logic [ValW-1:0]  val_a, val_b;

  psrr_pkg::back_state_t state_r, state_nxt;
  psrr_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CntW-1:0]       issue_r, issue_nxt;
  logic                  live_r, live_nxt;
  logic [AddrW-1:0]      pa_r, pa_nxt, pb_r, pb_nxt;
  logic [AddrW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ValW-1:0]       moved_r, moved_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic [ValW-1:0]       out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  issuing;
  logic                  sweep_done;
  logic                  rv_more, rt_more;

  // Store write and registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rdat_a_r <= store_mem[rd_a_addr];
      radr_a_r <= rd_a_addr;
    end
    if (rd_b_en) begin
      rdat_b_r <= store_mem[rd_b_addr];
      radr_b_r <= rd_b_addr;
    end
  end

  // Valid bits: cleared by reset and by init, set by any write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvld_a_r <= 1'b0;
      rvld_b_r <= 1'b0;
    end else begin
      if (clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_a_en) begin
        rvld_a_r <= vld_r[rd_a_addr];
      end
      if (rd_b_en) begin
        rvld_b_r <= vld_r[rd_b_addr];
      end
    end
  end

  assign val_a = rvld_a_r ? rdat_a_r : ValW'(radr_a_r) + ValW'(1);
  assign val_b = rvld_b_r ? rdat_b_r : ValW'(radr_b_r) + ValW'(1);

  // Loop conditions for the sweep and the two permutations.
  assign issuing    = (state_r == psrr_pkg::BK_SWEEP) && (issue_r < cmd_r.count);
  assign sweep_done = live_r && (issue_r == cmd_r.count);
  assign rv_more    = (CntW'(lo_r) + CntW'(2)) < CntW'(hi_r);
  assign rt_more    = (CntW'(lo_r) + CntW'(1)) < CntW'(hi_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psrr_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_stat.head.op == psrr_pkg::OP_INIT) ? psrr_pkg::BK_IDLE
                                                            : psrr_pkg::BK_SWEEP;
        end
      end
      psrr_pkg::BK_SWEEP: begin
        if (sweep_done) begin
          state_nxt = (cmd_r.op == psrr_pkg::OP_DUMP) ? psrr_pkg::BK_IDLE
                                                      : psrr_pkg::BK_CHECK;
        end
      end
      psrr_pkg::BK_CHECK: begin
        if (pa_r >= pb_r) begin
          state_nxt = psrr_pkg::BK_IDLE;
        end else if (cmd_r.op == psrr_pkg::OP_REVERSE) begin
          state_nxt = psrr_pkg::BK_RV_READ;
        end else begin
          state_nxt = psrr_pkg::BK_RT_READ;
        end
      end
      psrr_pkg::BK_RV_READ:  state_nxt = psrr_pkg::BK_RV_WLO;
      psrr_pkg::BK_RV_WLO:   state_nxt = psrr_pkg::BK_RV_WHI;
      psrr_pkg::BK_RV_WHI: begin
        state_nxt = rv_more ? psrr_pkg::BK_RV_READ : psrr_pkg::BK_IDLE;
      end
      psrr_pkg::BK_RT_READ:  state_nxt = psrr_pkg::BK_RT_MOVE;
      psrr_pkg::BK_RT_MOVE:  state_nxt = psrr_pkg::BK_RT_SHIFT;
      psrr_pkg::BK_RT_SHIFT: begin
        state_nxt = rt_more ? psrr_pkg::BK_RT_SHIFT : psrr_pkg::BK_RT_LAST;
      end
      psrr_pkg::BK_RT_LAST:  state_nxt = psrr_pkg::BK_IDLE;
      default:               state_nxt = psrr_pkg::BK_IDLE;
    endcase
  end

  // Store controls and datapath register updates for each state.
  always_comb begin
    q_pop          = 1'b0;
    rd_a_en        = 1'b0;
    rd_a_addr      = issue_r[AddrW-1:0];
    rd_b_en        = 1'b0;
    rd_b_addr      = hi_r;
    wr_en          = 1'b0;
    wr_addr        = lo_r;
    wr_data        = val_b;
    clr_all        = 1'b0;
    cmd_nxt        = cmd_r;
    issue_nxt      = issue_r;
    live_nxt       = 1'b0;
    pa_nxt         = pa_r;
    pb_nxt         = pb_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    moved_nxt      = moved_r;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      psrr_pkg::BK_IDLE: begin
        // Take the next request; init only drops every written entry.
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_stat.head;
          issue_nxt = '0;
          pa_nxt    = '0;
          pb_nxt    = '0;
          clr_all   = (q_stat.head.op == psrr_pkg::OP_INIT);
        end
      end
      psrr_pkg::BK_SWEEP: begin
        // Read the entries in use front first, one a cycle.
        if (issuing) begin
          rd_a_en   = 1'b1;
          issue_nxt = issue_r + 1'b1;
          live_nxt  = 1'b1;
        end
        // Emit for a dump, otherwise record where each value stands.
        if (live_r) begin
          if (cmd_r.op == psrr_pkg::OP_DUMP) begin
            out_strobe_nxt = 1'b1;
            out_value_nxt  = val_a;
            out_last_nxt   = (CntW'(radr_a_r) + CntW'(1)) == cmd_r.count;
          end else begin
            if (val_a == cmd_r.first_value) begin
              pa_nxt = radr_a_r;
            end
            if (val_a == cmd_r.second_value) begin
              pb_nxt = radr_a_r;
            end
          end
        end
      end
      psrr_pkg::BK_CHECK: begin
        lo_nxt = pa_r;
        hi_nxt = pb_r;
      end
      psrr_pkg::BK_RV_READ: begin
        rd_a_en   = 1'b1;
        rd_a_addr = lo_r;
        rd_b_en   = 1'b1;
        rd_b_addr = hi_r;
      end
      psrr_pkg::BK_RV_WLO: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
        wr_data = val_b;
      end
      psrr_pkg::BK_RV_WHI: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = val_a;
        lo_nxt  = lo_r + 1'b1;
        hi_nxt  = hi_r - 1'b1;
      end
      psrr_pkg::BK_RT_READ: begin
        rd_a_en   = 1'b1;
        rd_a_addr = lo_r;
      end
      psrr_pkg::BK_RT_MOVE: begin
        moved_nxt = val_a;
        rd_a_en   = 1'b1;
        rd_a_addr = lo_r + 1'b1;
      end
      psrr_pkg::BK_RT_SHIFT: begin
        // Write one place toward the front while the next entry is read.
        wr_en   = 1'b1;
        wr_addr = lo_r;
        wr_data = val_a;
        lo_nxt  = lo_r + 1'b1;
        if (rt_more) begin
          rd_a_en   = 1'b1;
          rd_a_addr = lo_r + AddrW'(2);
        end
      end
      psrr_pkg::BK_RT_LAST: begin
        wr_en   = 1'b1;
        wr_addr = hi_r;
        wr_data = moved_r;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psrr_pkg::BK_IDLE;
      live_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    issue_r     <= issue_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    moved_r     <= moved_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_entry_value = out_value_r;
  assign out_last_entry  = out_last_r;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for permutation_segment_reverse_rotate: random and directed requests
// are checked against a cycle-free model of the permutation store kept inside the bench.
// Depends on psrr_pkg for the opcode type and field widths.
module tb;

  localparam int StoreDepth  = 64;
  localparam int DrainCycles = 600;
  localparam int WatchLimit  = 5000;

  typedef struct packed {
    psrr_pkg::op_t               op;
    logic [psrr_pkg::ValW-1:0]   first_value;
    logic [psrr_pkg::ValW-1:0]   second_value;
  } seg_request_t;

  typedef struct packed {
    logic [psrr_pkg::ValW-1:0] value;
    logic                      last;
  } dump_entry_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  logic [psrr_pkg::OpW-1:0]  in_opcode = '0;
  logic [psrr_pkg::ValW-1:0] in_first_value = '0;
  logic [psrr_pkg::ValW-1:0] in_second_value = '0;
  logic out_strobe;
  logic [psrr_pkg::ValW-1:0] out_entry_value;
  logic out_last_entry;
  logic cfg_valid;
  logic cfg_ready;
  logic [psrr_pkg::CfgW-1:0] cfg_entry_count;

  // Bench-side copy of the store and the entry count register.
  logic [psrr_pkg::ValW-1:0] perm_store [StoreDepth];
  logic [psrr_pkg::CfgW-1:0] entry_count_model;

  seg_request_t request_backlog[$];
  dump_entry_t  dump_entries_due[$];
  seg_request_t driven_request;
  int           sender_idle_pct;
  int           error_count = 0;
  int           quiet_cycles = 0;

  permutation_segment_reverse_rotate i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .out_strobe      (out_strobe),
    .out_entry_value (out_entry_value),
    .out_last_entry  (out_last_entry),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_entry_count (cfg_entry_count)
  );

  always #1 clk = ~clk;

  // The count in use is the register clamped to 1..StoreDepth.
  function automatic int active_entries();
    if (entry_count_model < 1) begin
      return 1;
    end
    if (entry_count_model > StoreDepth) begin
      return StoreDepth;
    end
    return int'(entry_count_model);
  endfunction

  function automatic void fill_identity();
    for (int i = 0; i < StoreDepth; i++) begin
      perm_store[i] = psrr_pkg::ValW'(i + 1);
    end
  endfunction

  // First match from the front among the entries in use; a miss counts as the front.
  function automatic int locate_value(logic [psrr_pkg::ValW-1:0] value, int used);
    for (int i = 0; i < used; i++) begin
      if (perm_store[i] == value) begin
        return i;
      end
    end
    return 0;
  endfunction

  // Apply one accepted request to the store and queue any dump entries it yields.
  function automatic void apply_command(seg_request_t req);
    int used;
    int lo;
    int hi;
    logic [psrr_pkg::ValW-1:0] held;
    dump_entry_t entry;
    used = active_entries();
    case (req.op)
      psrr_pkg::OP_INIT: begin
        fill_identity();
      end
      psrr_pkg::OP_DUMP: begin
        for (int i = 0; i < used; i++) begin
          entry.value = perm_store[i];
          entry.last  = (i == used - 1);
          dump_entries_due.push_back(entry);
        end
      end
      default: begin
        lo = locate_value(req.first_value, used);
        hi = locate_value(req.second_value, used);
        // A segment that is empty or backwards leaves the store alone.
        if (lo < hi) begin
          if (req.op == psrr_pkg::OP_REVERSE) begin
            while (lo < hi) begin
              held           = perm_store[lo];
              perm_store[lo] = perm_store[hi];
              perm_store[hi] = held;
              lo++;
              hi--;
            end
          end else begin
            held = perm_store[lo];
            for (int i = lo; i < hi; i++) begin
              perm_store[i] = perm_store[i + 1];
            end
            perm_store[hi] = held;
          end
        end
      end
    endcase
  endfunction

  // Driver: a request is taken when start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(driven_request);
      end
      if (!start || !busy) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          driven_request = request_backlog.pop_front();
          start           <= 1'b1;
          in_opcode       <= driven_request.op;
          in_first_value  <= driven_request.first_value;
          in_second_value <= driven_request.second_value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest pending dump entry.
  always @(posedge clk) begin
    dump_entry_t due;
    if (rst_n && out_strobe) begin
      if (dump_entries_due.size() == 0) begin
        $display("%0t: unexpected entry value=%0d last=%0b", $time, out_entry_value,
                 out_last_entry);
        error_count++;
      end else begin
        due = dump_entries_due.pop_front();
        if (out_entry_value !== due.value) begin
          $display("%0t: entry_value mismatch: expected %0d, actual %0d", $time, due.value,
                   out_entry_value);
          error_count++;
        end
        if (out_last_entry !== due.last) begin
          $display("%0t: last_entry mismatch: expected %0b, actual %0b", $time, due.last,
                   out_last_entry);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing is accepted for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WatchLimit);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(psrr_pkg::op_t op, int first_value, int second_value);
    seg_request_t req;
    req.op           = op;
    req.first_value  = psrr_pkg::ValW'(first_value);
    req.second_value = psrr_pkg::ValW'(second_value);
    request_backlog.push_back(req);
  endtask

  // Hold off until every request is taken and every dump entry has arrived.
  task automatic wait_drained();
    while (request_backlog.size() != 0 || start || dump_entries_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_entry_count(int value);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_entry_count <= psrr_pkg::CfgW'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid         <= 1'b0;
    entry_count_model = psrr_pkg::CfgW'(value);
  endtask

  // Mostly values in use, with some misses spread over the whole field.
  function automatic int pick_value();
    if ($urandom_range(99) < 85) begin
      return $urandom_range(1, active_entries());
    end
    return $urandom_range(0, 127);
  endfunction

  task automatic run_phase(int count_value, int items, int idle_pct);
    int pick;
    psrr_pkg::op_t op;
    wait_drained();
    write_entry_count(count_value);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        op = psrr_pkg::OP_INIT;
      end else if (pick < 20) begin
        op = psrr_pkg::OP_DUMP;
      end else if (pick < 60) begin
        op = psrr_pkg::OP_REVERSE;
      end else begin
        op = psrr_pkg::OP_ROTATE;
      end
      push_request(op, pick_value(), pick_value());
    end
    push_request(psrr_pkg::OP_DUMP, 0, 0);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_entry_count   = '0;
    sender_idle_pct   = 15;
    entry_count_model = psrr_pkg::CfgW'(64);
    fill_identity();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset count of 64.
    push_request(psrr_pkg::OP_DUMP, 0, 0);
    push_request(psrr_pkg::OP_REVERSE, 1, 64);
    push_request(psrr_pkg::OP_DUMP, 127, 127);
    // Move the front value to the very end.
    push_request(psrr_pkg::OP_ROTATE, 64, 1);
    // First value stands after the second: no change.
    push_request(psrr_pkg::OP_REVERSE, 10, 20);
    // Equal positions: no change.
    push_request(psrr_pkg::OP_REVERSE, 5, 5);
    push_request(psrr_pkg::OP_ROTATE, 5, 5);
    // Values that are not in the store count as the front position.
    push_request(psrr_pkg::OP_ROTATE, 0, 30);
    push_request(psrr_pkg::OP_REVERSE, 127, 64);
    push_request(psrr_pkg::OP_ROTATE, 64, 100);
    push_request(psrr_pkg::OP_DUMP, 85, 42);
    push_request(psrr_pkg::OP_INIT, 127, 127);
    push_request(psrr_pkg::OP_DUMP, 0, 0);
    // Adjacent segments and a segment to the last position.
    push_request(psrr_pkg::OP_ROTATE, 1, 2);
    push_request(psrr_pkg::OP_REVERSE, 3, 4);
    push_request(psrr_pkg::OP_ROTATE, 1, 64);
    push_request(psrr_pkg::OP_DUMP, 0, 0);
    push_request(psrr_pkg::OP_REVERSE, 85, 42);
    push_request(psrr_pkg::OP_ROTATE, 42, 85);
    push_request(psrr_pkg::OP_DUMP, 0, 0);

    // Random phases over several counts, including zero and values above the store size.
    run_phase(1, 30, 15);
    run_phase(0, 15, 15);
    run_phase(127, 40, 52);
    run_phase(2, 30, 52);
    run_phase($urandom_range(3, 63), 55, 0);
    run_phase(64, 60, 0);
    wait_drained();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/psrr_pkg.sv
hw/rtl/psrr_front.sv
hw/rtl/psrr_queue.sv
hw/rtl/psrr_back.sv
hw/rtl/permutation_segment_reverse_rotate.sv
tb/sv/tb.sv
